/* src/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Check an implication in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

/* src/imh_pkg.sv */
// Package for the indexed max-heap core: types, codes and sizing constants.
// Depends on nothing.
`default_nettype none
package imh_pkg;
	localparam int unsigned CAPACITY_DEF = 4096;
	localparam int unsigned VERTICES     = 4096;
	localparam int unsigned VW           = 12;
	localparam int unsigned WW           = 32;
	localparam int unsigned CW           = 13;
	localparam int unsigned QDEPTH       = 2;

	typedef enum logic [1:0] {
		MODE_INSERT  = 2'd0,
		MODE_DELETE  = 2'd1,
		MODE_EXTRACT = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ABSENT  = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_FULL    = 3'd3,
		ST_PRESENT = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]    mode;
		logic [VW-1:0] vertex_id;
		logic [WW-1:0] item_weight;
	} cmd_t;

	typedef struct packed {
		logic [2:0]    status;
		logic [VW-1:0] out_vertex;
		logic [WW-1:0] out_weight;
		logic [CW-1:0] entry_count;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE, S_MAP_RD, S_MAP_WT, S_DISPATCH,
		S_INS_WR,
		S_DEL_RDL, S_DEL_WTL, S_DEL_WR,
		S_EXT_RD0, S_EXT_WT0, S_EXT_RDL, S_EXT_WTL,
		S_UP_RDP, S_UP_WTP, S_UP_SWAP,
		S_DN_RDL, S_DN_WTL, S_DN_RDR, S_DN_WTR, S_DN_SWAP,
		S_DN_SWAP2, S_UP_SWAP2,
		S_CLEAR, S_DONE
	} bstate_t;
endpackage
`default_nettype wire

/* src/imh_front.sv */
// Front end: takes commands and queues them for the heap engine.
// Depends on imh_pkg.
`default_nettype none
module imh_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire imh_pkg::cmd_t cmd,
	output logic               busy,
	input  wire logic          pop,
	output logic               q_valid,
	output imh_pkg::cmd_t      q_head
);
	imh_pkg::cmd_t q_mem_q [imh_pkg::QDEPTH];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       push;

	assign busy    = (cnt_q == 2'(imh_pkg::QDEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head  = q_mem_q[rd_q];

	// Advance queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Hold payload in the queue slots
	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_q] <= cmd;
	end
endmodule
`default_nettype wire

/* src/imh_back.sv */
// Back end: executes heap operations on the slot and map memories.
// Depends on imh_pkg.
`default_nettype none
module imh_back #(
	parameter int unsigned CAPACITY = imh_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire imh_pkg::cmd_t q_head,
	output logic               pop,
	output logic               done,
	output imh_pkg::res_t      res
);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned SW = AW + 1;
	localparam int unsigned MW = $clog2(imh_pkg::VERTICES);
	localparam int unsigned HEW = imh_pkg::VW + imh_pkg::WW;

	// Heap slot memory and position map memory
	logic [HEW-1:0]  heap_mem [CAPACITY];
	logic [SW-1:0]   map_mem  [imh_pkg::VERTICES];
	logic [HEW-1:0]  h_rd_q;
	logic [SW-1:0]   m_rd_q;

	logic            h_we, m_we;
	logic [AW-1:0]   h_wa, h_ra;
	logic [HEW-1:0]  h_wd;
	logic [MW-1:0]   m_wa, m_ra;
	logic [SW-1:0]   m_wd;

	imh_pkg::bstate_t st_q, st_d;
	imh_pkg::cmd_t    cmd_q, cmd_d;
	logic [SW-1:0]    cnt_q, cnt_d;
	logic [AW-1:0]    i_q, i_d, j_q, j_d;
	logic [HEW-1:0]   cur_q, cur_d, oth_q, oth_d, ext_q, ext_d;
	logic [2:0]       stat_q, stat_d;
	logic [MW-1:0]    clr_q, clr_d;
	logic             try_dn_q, try_dn_d;
	logic             rdone;

	// Read ports: registered data
	always_ff @(posedge clk) begin
		if (h_we) heap_mem[h_wa] <= h_wd;
		h_rd_q <= heap_mem[h_ra];
	end
	always_ff @(posedge clk) begin
		if (m_we) map_mem[m_wa] <= m_wd;
		m_rd_q <= map_mem[m_ra];
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= imh_pkg::S_CLEAR;
			cnt_q <= '0;
			clr_q <= '0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			clr_q <= clr_d;
		end
	end
	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		i_q      <= i_d;
		j_q      <= j_d;
		cur_q    <= cur_d;
		oth_q    <= oth_d;
		ext_q    <= ext_d;
		stat_q   <= stat_d;
		try_dn_q <= try_dn_d;
	end

	function automatic logic [imh_pkg::WW-1:0] wt(input logic [HEW-1:0] e);
		return e[imh_pkg::WW-1:0];
	endfunction
	function automatic logic [MW-1:0] vx(input logic [HEW-1:0] e);
		return e[HEW-1:imh_pkg::WW];
	endfunction

	logic [SW-1:0] lidx, ridx, last;
	assign lidx = {i_q, 1'b1};
	assign ridx = {i_q, 1'b0} + SW'(2);
	assign last = cnt_q - SW'(1);

	// Sequence each operation
	always_comb begin
		st_d = st_q; cmd_d = cmd_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q;
		cur_d = cur_q; oth_d = oth_q; ext_d = ext_q; stat_d = stat_q; clr_d = clr_q;
		try_dn_d = try_dn_q;
		h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
		m_we = 1'b0; m_wa = '0; m_wd = '0; m_ra = cmd_q.vertex_id;
		pop = 1'b0; rdone = 1'b0;
		unique case (st_q)
			imh_pkg::S_CLEAR: begin
				m_we = 1'b1; m_wa = clr_q; m_wd = '1;
				clr_d = clr_q + 1'b1;
				if (clr_q == '1) st_d = imh_pkg::S_IDLE;
			end
			imh_pkg::S_IDLE: begin
				if (q_valid) begin
					pop = 1'b1; cmd_d = q_head; ext_d = '0; try_dn_d = 1'b0;
					stat_d = imh_pkg::ST_OK; st_d = imh_pkg::S_MAP_RD;
				end
			end
			imh_pkg::S_MAP_RD: st_d = imh_pkg::S_MAP_WT;
			imh_pkg::S_MAP_WT: st_d = imh_pkg::S_DISPATCH;
			imh_pkg::S_DISPATCH: begin
				st_d = imh_pkg::S_DONE;
				unique case (cmd_q.mode)
					imh_pkg::MODE_INSERT: begin
						if (cnt_q >= SW'(CAPACITY)) stat_d = imh_pkg::ST_FULL;
						else if (m_rd_q != '1) stat_d = imh_pkg::ST_PRESENT;
						else begin
							i_d = cnt_q[AW-1:0];
							cur_d = {cmd_q.vertex_id, cmd_q.item_weight};
							cnt_d = cnt_q + 1'b1;
							st_d = imh_pkg::S_INS_WR;
						end
					end
					imh_pkg::MODE_DELETE: begin
						if (m_rd_q == '1) stat_d = imh_pkg::ST_ABSENT;
						else begin
							m_we = 1'b1; m_wa = cmd_q.vertex_id; m_wd = '1;
							i_d = m_rd_q[AW-1:0];
							cnt_d = last;
							if (m_rd_q[AW-1:0] != last[AW-1:0]) st_d = imh_pkg::S_DEL_RDL;
						end
					end
					imh_pkg::MODE_EXTRACT: begin
						if (cnt_q == '0) stat_d = imh_pkg::ST_EMPTY;
						else st_d = imh_pkg::S_EXT_RD0;
					end
					default: ;
				endcase
			end
			imh_pkg::S_INS_WR: begin
				h_we = 1'b1; h_wa = i_q; h_wd = cur_q;
				m_we = 1'b1; m_wa = vx(cur_q); m_wd = SW'(i_q);
				st_d = (i_q == '0) ? imh_pkg::S_DONE : imh_pkg::S_UP_RDP;
			end
			imh_pkg::S_DEL_RDL: begin
				h_ra = cnt_q[AW-1:0]; st_d = imh_pkg::S_DEL_WTL;
			end
			imh_pkg::S_DEL_WTL: begin
				cur_d = h_rd_q; st_d = imh_pkg::S_DEL_WR;
			end
			imh_pkg::S_DEL_WR: begin
				// Place last entry, then sift down at the root or decide direction against parent
				h_we = 1'b1; h_wa = i_q; h_wd = cur_q;
				m_we = 1'b1; m_wa = vx(cur_q); m_wd = SW'(i_q);
				try_dn_d = 1'b1;
				st_d = (i_q == '0) ? imh_pkg::S_DN_RDL : imh_pkg::S_UP_RDP;
			end
			imh_pkg::S_EXT_RD0: begin
				h_ra = '0; st_d = imh_pkg::S_EXT_WT0;
			end
			imh_pkg::S_EXT_WT0: begin
				ext_d = h_rd_q;
				m_we = 1'b1; m_wa = vx(h_rd_q); m_wd = '1;
				cnt_d = last; i_d = '0;
				st_d = (last == '0) ? imh_pkg::S_DONE : imh_pkg::S_EXT_RDL;
			end
			imh_pkg::S_EXT_RDL: begin
				h_ra = cnt_q[AW-1:0]; st_d = imh_pkg::S_EXT_WTL;
			end
			imh_pkg::S_EXT_WTL: begin
				cur_d = h_rd_q;
				h_we = 1'b1; h_wa = '0; h_wd = h_rd_q;
				m_we = 1'b1; m_wa = vx(h_rd_q); m_wd = '0;
				st_d = imh_pkg::S_DN_RDL;
			end
			// Sift up: compare with parent, swap while strictly heavier
			imh_pkg::S_UP_RDP: begin
				j_d = (i_q - 1'b1) >> 1;
				h_ra = (i_q - 1'b1) >> 1; st_d = imh_pkg::S_UP_WTP;
			end
			imh_pkg::S_UP_WTP: begin
				oth_d = h_rd_q;
				// A delete whose moved entry does not rise sifts down instead
				if (wt(cur_q) > wt(h_rd_q)) st_d = imh_pkg::S_UP_SWAP;
				else if (try_dn_q) st_d = imh_pkg::S_DN_RDL;
				else st_d = imh_pkg::S_DONE;
			end
			imh_pkg::S_UP_SWAP: begin
				h_we = 1'b1; h_wa = j_q; h_wd = cur_q;
				m_we = 1'b1; m_wa = vx(cur_q); m_wd = SW'(j_q);
				try_dn_d = 1'b0;
				st_d = imh_pkg::S_UP_SWAP2;
			end
			imh_pkg::S_UP_SWAP2: begin
				h_we = 1'b1; h_wa = i_q; h_wd = oth_q;
				m_we = 1'b1; m_wa = vx(oth_q); m_wd = SW'(i_q);
				i_d = j_q;
				st_d = (j_q == '0) ? imh_pkg::S_DONE : imh_pkg::S_UP_RDP;
			end
			// Sift down: pick strictly heavier child, left wins ties
			imh_pkg::S_DN_RDL: begin
				j_d = i_q;
				oth_d = cur_q;
				if (lidx < cnt_q) begin
					h_ra = lidx[AW-1:0]; st_d = imh_pkg::S_DN_WTL;
				end else st_d = imh_pkg::S_DONE;
			end
			imh_pkg::S_DN_WTL: begin
				if (wt(h_rd_q) > wt(oth_q)) begin
					oth_d = h_rd_q; j_d = lidx[AW-1:0];
				end
				st_d = imh_pkg::S_DN_RDR;
			end
			imh_pkg::S_DN_RDR: begin
				if (ridx < cnt_q) begin
					h_ra = ridx[AW-1:0]; st_d = imh_pkg::S_DN_WTR;
				end else st_d = (j_q == i_q) ? imh_pkg::S_DONE : imh_pkg::S_DN_SWAP;
			end
			imh_pkg::S_DN_WTR: begin
				if (wt(h_rd_q) > wt(oth_q)) begin
					oth_d = h_rd_q; j_d = ridx[AW-1:0];
					st_d = imh_pkg::S_DN_SWAP;
				end else st_d = (j_q == i_q) ? imh_pkg::S_DONE : imh_pkg::S_DN_SWAP;
			end
			imh_pkg::S_DN_SWAP: begin
				h_we = 1'b1; h_wa = i_q; h_wd = oth_q;
				m_we = 1'b1; m_wa = vx(oth_q); m_wd = SW'(i_q);
				st_d = imh_pkg::S_DN_SWAP2;
			end
			imh_pkg::S_DN_SWAP2: begin
				h_we = 1'b1; h_wa = j_q; h_wd = cur_q;
				m_we = 1'b1; m_wa = vx(cur_q); m_wd = SW'(j_q);
				i_d = j_q;
				st_d = imh_pkg::S_DN_RDL;
			end
			imh_pkg::S_DONE: begin
				rdone = 1'b1; st_d = imh_pkg::S_IDLE;
			end
			default: st_d = imh_pkg::S_IDLE;
		endcase
	end

	// Drive the result register for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= rdone;
	end
	always_ff @(posedge clk) begin
		res.status      <= stat_q;
		res.out_vertex  <= ext_q[HEW-1:imh_pkg::WW];
		res.out_weight  <= ext_q[imh_pkg::WW-1:0];
		res.entry_count <= imh_pkg::CW'(cnt_q);
	end
endmodule
`default_nettype wire

/* src/indexed_max_heap_core.sv */
// Top level of the indexed max-heap core: command queue and heap engine.
// Depends on imh_pkg, imh_front and imh_back.
// One command at a time runs in the engine while up to two more wait in the queue.
// A command that only reports a status, or a delete of the last slot, passes through
// the map read, map wait, dispatch and done states; other inserts, deletes and extracts
// also place an entry, then compare and swap with the parent per level sifted up or
// with the heavier child per level sifted down, bounded by the heap depth (log2 CAPACITY);
// the slot memory has one read port, one write port and registered reads.
// After reset a clearing pass empties every entry of the position map.
// Results appear on done for one cycle; the receiver cannot stall them.
`default_nettype none
module indexed_max_heap_core #(
	parameter int unsigned CAPACITY = imh_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire imh_pkg::cmd_t cmd,
	output logic               busy,
	output logic               done,
	output imh_pkg::res_t      res
);
	logic          q_valid, pop;
	imh_pkg::cmd_t q_head;

	imh_front u_front (
		.clk, .arst_n, .start, .cmd, .busy, .pop, .q_valid, .q_head
	);
	imh_back #(.CAPACITY(CAPACITY)) u_back (
		.clk, .arst_n, .q_valid, .q_head, .pop, .done, .res
	);
endmodule
`default_nettype wire

/* src/imh_checker.sv */
// Port checker for the indexed max-heap core, bound to the top level.
// Depends on imh_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module imh_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          done,
	input wire imh_pkg::res_t res
);
	`CHK_IMPL(a_status_range, clk, arst_n, done, res.status <= imh_pkg::ST_PRESENT)
	`CHK_NEXT(a_done_single, clk, arst_n, done, !done)
	`CHK_IMPL(a_empty_zero, clk, arst_n, done && res.status == imh_pkg::ST_EMPTY, res.out_weight == '0 && res.entry_count == '0)
	`CHK_IMPL(a_full_count, clk, arst_n, done && res.status == imh_pkg::ST_FULL, res.entry_count != '0)
endmodule
bind indexed_max_heap_core imh_checker u_chk (.clk, .arst_n, .done, .res);
`default_nettype wire
